[rtl/barometric_pressure_compensation_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the barometric pressure compensation block
// Shared helpers so that every checker states its properties the same way.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH

// property checked outside reset
`define BPC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BPC_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and helpers shared by the compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    // cycles from the accepting edge to the edge that samples the result strobe
    localparam int unsigned PIPE_LATENCY = 78;

    localparam int unsigned DIV_STEPS  = 32;
    localparam int unsigned DIV_SIDE_W = 58;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] X3_BIAS     = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] P_COEF_SQ   = 32'd3038;
    localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_COEF_OFS  = 32'd3791;
    localparam logic [19:0] PRESS_MAX   = 20'hF_FFFF;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure_bytes;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic        [19:0] pressure_pa;
        logic               divide_fault;
    } t_out_item;

    // calibration words, extended to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } t_cal;

    typedef logic [DIV_SIDE_W-1:0] t_div_side;

    // temperature stage result
    typedef struct packed {
        logic               vld;
        logic [31:0]        b5;
        logic signed [15:0] t;
        logic               fault;
        logic [23:0]        up;
    } t_temp_res;

    // pressure coefficient stage result
    typedef struct packed {
        logic               vld;
        logic [31:0]        b4;
        logic [31:0]        b7;
        logic signed [15:0] t;
        logic               fault;
    } t_coef_res;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    // low 32 bits of a product
    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] full;
        full = 64'(a) * 64'(b);
        return full[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/bpc_udiv.sv]
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_udiv
    import bpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    input  wire t_div_side   i_side,
    output logic             o_vld,
    output logic [31:0]      o_quot,
    output t_div_side        o_side
);

    logic        r_vld  [0:DIV_STEPS];
    logic [31:0] r_rem  [0:DIV_STEPS];
    logic [31:0] r_qd   [0:DIV_STEPS];
    logic [31:0] r_dvs  [0:DIV_STEPS];
    t_div_side   r_side [0:DIV_STEPS];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_qd[0]   <= i_dividend;
        r_dvs[0]  <= i_divisor;
        r_side[0] <= i_side;
    end

    // one restoring step per stage: dividend shifts out, quotient shifts in
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [32:0] rem_sh;
        logic [33:0] diff;
        logic        ge;

        always_comb begin
            rem_sh = {r_rem[g], r_qd[g][31]};
            diff   = {1'b0, rem_sh} - {2'b00, r_dvs[g]};
            ge     = ~diff[33];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= ge ? diff[31:0] : rem_sh[31:0];
            r_qd[g+1]   <= {r_qd[g][30:0], ge};
            r_dvs[g+1]  <= r_dvs[g];
            r_side[g+1] <= r_side[g];
        end
    end

    assign o_vld  = r_vld[DIV_STEPS];
    assign o_quot = r_qd[DIV_STEPS];
    assign o_side = r_side[DIV_STEPS];

endmodule

`default_nettype wire

[rtl/bpc_temp.sv]
// ----------------------------------------------------------------------------
// bpc_temp
// Temperature half: x1 product, signed x2 quotient, b5 and tenths of a degree.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_temp
    import bpc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_vld,
    input  wire t_in_item i_item,
    input  wire t_cal     i_cal,
    output t_temp_res     o_res
);

    logic        r0_vld, r1_vld, r3_vld;
    logic [15:0] r0_ut;
    logic [23:0] r0_up, r1_up;
    logic [31:0] r1_m;

    logic [31:0] x1, dvs, num, mag_n, mag_d;
    t_div_side   div_side;
    logic        dq_vld;
    logic [31:0] dq;
    t_div_side   dq_side;

    logic [31:0] q_x1, x2, b5, tsh;
    logic        q_neg, q_fault;
    logic [23:0] q_up;
    logic signed [15:0] t_sat;

    logic [31:0]        r3_b5;
    logic signed [15:0] r3_t;
    logic               r3_fault;
    logic [23:0]        r3_up;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            r3_vld <= dq_vld;
        end
    end

    // capture beat, align raw pressure, then (ut - ac6) * ac5
    always_ff @(posedge i_clk) begin
        r0_ut <= i_item.raw_temperature;
        r0_up <= i_item.raw_pressure_bytes >> (4'd8 - {2'b00, i_cal.oss});
        r1_m  <= mul_lo({16'h0000, r0_ut} - i_cal.ac6, i_cal.ac5);
        r1_up <= r0_up;
    end

    // divisor x1 + md, magnitudes for the signed quotient
    always_comb begin
        x1       = asr(r1_m, 5'd15);
        dvs      = x1 + i_cal.md;
        num      = {i_cal.mc[20:0], 11'h000};
        mag_n    = num[31] ? (32'h0 - num) : num;
        mag_d    = dvs[31] ? (32'h0 - dvs) : dvs;
        div_side = {x1, num[31] ^ dvs[31], dvs == 32'h0, r1_up};
    end

    bpc_udiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r1_vld),
        .i_dividend (mag_n),
        .i_divisor  (mag_d),
        .i_side     (div_side),
        .o_vld      (dq_vld),
        .o_quot     (dq),
        .o_side     (dq_side)
    );

    // b5 and the saturated temperature
    always_comb begin
        {q_x1, q_neg, q_fault, q_up} = dq_side;
        x2  = q_neg ? (32'h0 - dq) : dq;
        b5  = q_x1 + x2;
        tsh = asr(b5 + 32'd8, 5'd4);
        if ($signed(tsh) > 32'sd32767) begin
            t_sat = 16'sh7FFF;
        end else if ($signed(tsh) < -32'sd32768) begin
            t_sat = -16'sh8000;
        end else begin
            t_sat = tsh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_b5    <= b5;
        r3_t     <= t_sat;
        r3_fault <= q_fault;
        r3_up    <= q_up;
    end

    assign o_res = '{vld: r3_vld, b5: r3_b5, t: r3_t, fault: r3_fault, up: r3_up};

endmodule

`default_nettype wire

[rtl/bpc_coef.sv]
// ----------------------------------------------------------------------------
// bpc_coef
// Pressure coefficients: b6, b3, b4 and b7, at most one multiplier level per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_coef
    import bpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_temp_res i_res,
    input  wire t_cal      i_cal,
    output t_coef_res      o_res
);

    logic r4_vld, r5_vld, r6_vld, r7_vld, r8_vld, r9_vld;

    logic signed [15:0] r4_t, r5_t, r6_t, r7_t, r8_t, r9_t;
    logic r4_fault, r5_fault, r6_fault, r7_fault, r8_fault, r9_fault;
    logic [23:0] r4_up, r5_up, r6_up, r7_up;

    logic [31:0] b6;
    logic [31:0] r4_sqf, r4_a2, r4_a3;
    logic [31:0] r5_sq, r5_x2a, r5_x1b;
    logic [31:0] r6_b2sq, r6_b1sq, r6_x2a, r6_x1b;
    logic [31:0] x3a, v3, b3, x3b;
    logic [31:0] r7_b3, r7_x3b;
    logic [31:0] r8_prod, r8_diff;
    logic [31:0] r9_b4, r9_b7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
        end else begin
            r4_vld <= i_res.vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
            r9_vld <= r8_vld;
        end
    end

    // b6 products
    assign b6 = i_res.b5 - B6_OFFSET;

    always_ff @(posedge i_clk) begin
        r4_sqf   <= mul_lo(b6, b6);
        r4_a2    <= mul_lo(i_cal.ac2, b6);
        r4_a3    <= mul_lo(i_cal.ac3, b6);
        r4_t     <= i_res.t;
        r4_fault <= i_res.fault;
        r4_up    <= i_res.up;
    end

    // scale
    always_ff @(posedge i_clk) begin
        r5_sq    <= asr(r4_sqf, 5'd12);
        r5_x2a   <= asr(r4_a2, 5'd11);
        r5_x1b   <= asr(r4_a3, 5'd13);
        r5_t     <= r4_t;
        r5_fault <= r4_fault;
        r5_up    <= r4_up;
    end

    // products with the squared term
    always_ff @(posedge i_clk) begin
        r6_b2sq  <= mul_lo(i_cal.b2, r5_sq);
        r6_b1sq  <= mul_lo(i_cal.b1, r5_sq);
        r6_x2a   <= r5_x2a;
        r6_x1b   <= r5_x1b;
        r6_t     <= r5_t;
        r6_fault <= r5_fault;
        r6_up    <= r5_up;
    end

    // b3 (signed divide by four, toward zero) and x3 of the b4 term
    always_comb begin
        x3a = asr(r6_b2sq, 5'd11) + r6_x2a;
        v3  = (({i_cal.ac1[29:0], 2'b00} + x3a) << i_cal.oss) + 32'd2;
        b3  = v3[31] ? asr(v3 + 32'd3, 5'd2) : asr(v3, 5'd2);
        x3b = asr(r6_x1b + asr(r6_b1sq, 5'd16) + 32'd2, 5'd2);
    end

    always_ff @(posedge i_clk) begin
        r7_b3    <= b3;
        r7_x3b   <= x3b;
        r7_t     <= r6_t;
        r7_fault <= r6_fault;
        r7_up    <= r6_up;
    end

    // b4 product and up - b3
    always_ff @(posedge i_clk) begin
        r8_prod  <= mul_lo(i_cal.ac4, r7_x3b + X3_BIAS);
        r8_diff  <= {8'h00, r7_up} - r7_b3;
        r8_t     <= r7_t;
        r8_fault <= r7_fault;
    end

    // b4 and b7
    always_ff @(posedge i_clk) begin
        r9_b4    <= r8_prod >> 15;
        r9_b7    <= mul_lo(r8_diff, B7_SCALE >> i_cal.oss);
        r9_t     <= r8_t;
        r9_fault <= r8_fault;
    end

    assign o_res = '{vld: r9_vld, b4: r9_b4, b7: r9_b7, t: r9_t, fault: r9_fault};

endmodule

`default_nettype wire

[rtl/bpc_press.sv]
// ----------------------------------------------------------------------------
// bpc_press
// Pressure quotient, final polynomial correction and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_press
    import bpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_coef_res i_res,
    output logic           o_valid,
    output t_out_item      o_result
);

    logic        fault, path;
    logic [31:0] dividend;
    t_div_side   div_side;
    logic        dq_vld;
    logic [31:0] dq;
    t_div_side   dq_side;

    logic        q_path, q_fault;
    logic signed [15:0] q_t;
    logic [31:0] p, p8;

    logic r11_vld, r12_vld, r13_vld;
    logic [31:0] r11_p, r11_sq8, r11_lin, r12_p, r12_m, r12_x2;
    logic signed [15:0] r11_t, r12_t;
    logic r11_fault, r12_fault;

    logic [31:0] x1, pn;
    t_out_item   res;
    t_out_item   r13_res;

    // quotient path: small b7 doubles before dividing, large b7 after
    always_comb begin
        fault    = i_res.fault | (i_res.b4 == 32'h0);
        path     = i_res.b7[31];
        dividend = path ? i_res.b7 : {i_res.b7[30:0], 1'b0};
        div_side = {(DIV_SIDE_W - 18)'(0), path, fault, i_res.t};
    end

    bpc_udiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_res.vld),
        .i_dividend (dividend),
        .i_divisor  (i_res.b4),
        .i_side     (div_side),
        .o_vld      (dq_vld),
        .o_quot     (dq),
        .o_side     (dq_side)
    );

    always_comb begin
        q_path  = dq_side[17];
        q_fault = dq_side[16];
        q_t     = dq_side[15:0];
        p       = q_path ? {dq[30:0], 1'b0} : dq;
        p8      = asr(p, 5'd8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            r13_vld <= 1'b0;
        end else begin
            r11_vld <= dq_vld;
            r12_vld <= r11_vld;
            r13_vld <= r12_vld;
        end
    end

    // square and linear terms
    always_ff @(posedge i_clk) begin
        r11_p     <= p;
        r11_sq8   <= mul_lo(p8, p8);
        r11_lin   <= mul_lo(P_COEF_LIN, p);
        r11_t     <= q_t;
        r11_fault <= q_fault;
    end

    always_ff @(posedge i_clk) begin
        r12_p     <= r11_p;
        r12_m     <= mul_lo(r11_sq8, P_COEF_SQ);
        r12_x2    <= asr(r11_lin, 5'd16);
        r12_t     <= r11_t;
        r12_fault <= r11_fault;
    end

    // correction, saturation, fault zeroing
    always_comb begin
        x1 = asr(r12_m, 5'd16);
        pn = r12_p + asr(x1 + r12_x2 + P_COEF_OFS, 5'd4);
        res.divide_fault = r12_fault;
        if (r12_fault) begin
            res.temperature_tenths = '0;
            res.pressure_pa        = '0;
        end else begin
            res.temperature_tenths = r12_t;
            if (pn[31]) begin
                res.pressure_pa = '0;
            end else if (pn > {12'h000, PRESS_MAX}) begin
                res.pressure_pa = PRESS_MAX;
            end else begin
                res.pressure_pa = pn[19:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r13_res <= res;
    end

    assign o_valid  = r13_vld;
    assign o_result = r13_res;

endmodule

`default_nettype wire

[rtl/barometric_pressure_compensation_top.sv]
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Integer calibration compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a beat is taken at each rising edge with i_start high and o_busy
//   low. o_busy never rises, so a new reading may enter every cycle.
//   Output: o_valid strobes for one cycle with o_result; the receiver must
//   take it then, there is no back-pressure.
//   Pipeline: the result passes two pipelined dividers, each an entry
//   register and 32 restoring stages, plus the multiplier stages.
//   Throughput: one reading per cycle.
//   Calibration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once;
//   write only while no reading is in flight. Unused indexes are ignored.
//   Reset: synchronous, clears the configuration and valid registers
//   to zero, empties the pipeline; results of readings in flight are dropped.
//   A zero divisor gives divide_fault with zero temperature and pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_top
    import bpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_in_item    i_in,
    output logic             o_valid,
    output t_out_item        o_result,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [1:0]  r_oss;
    t_cal        cal;
    t_temp_res   temp_res;
    t_coef_res   coef_res;
    logic        accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AC1_AC2: r_ac1_ac2 <= i_cfg_data;
                CFG_AC3_AC4: r_ac3_ac4 <= i_cfg_data;
                CFG_AC5_AC6: r_ac5_ac6 <= i_cfg_data;
                CFG_B1_B2:   r_b1_b2   <= i_cfg_data;
                CFG_MC_MD:   r_mc_md   <= i_cfg_data;
                CFG_OSS:     r_oss     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // calibration words, sign or zero extended
    always_comb begin
        cal.ac1 = {{16{r_ac1_ac2[31]}}, r_ac1_ac2[31:16]};
        cal.ac2 = {{16{r_ac1_ac2[15]}}, r_ac1_ac2[15:0]};
        cal.ac3 = {{16{r_ac3_ac4[31]}}, r_ac3_ac4[31:16]};
        cal.ac4 = {16'h0000, r_ac3_ac4[15:0]};
        cal.ac5 = {16'h0000, r_ac5_ac6[31:16]};
        cal.ac6 = {16'h0000, r_ac5_ac6[15:0]};
        cal.b1  = {{16{r_b1_b2[31]}}, r_b1_b2[31:16]};
        cal.b2  = {{16{r_b1_b2[15]}}, r_b1_b2[15:0]};
        cal.mc  = {{16{r_mc_md[31]}}, r_mc_md[31:16]};
        cal.md  = {{16{r_mc_md[15]}}, r_mc_md[15:0]};
        cal.oss = r_oss;
    end

    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_item  (i_in),
        .i_cal   (cal),
        .o_res   (temp_res)
    );

    bpc_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (temp_res),
        .i_cal   (cal),
        .o_res   (coef_res)
    );

    bpc_press u_press (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (coef_res),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[rtl/bpc_checker.sv]
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "barometric_pressure_compensation_top_assert.svh"

module bpc_checker
    import bpc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_start,
    input wire logic      o_busy,
    input wire logic      o_valid,
    input wire t_out_item o_result
);

    // reset empties the pipeline
    `BPC_CHECK_ALWAYS(a_rst_clears, !i_rst_n |=> !o_valid, "strobe after reset")

    // every result beat traces back to an accepted beat
    `BPC_CHECK(a_latency, o_valid |-> $past(i_start && !o_busy, PIPE_LATENCY), "result without input")

    // a divide fault zeroes both values
    `BPC_CHECK(a_fault_zero, (o_valid && o_result.divide_fault) |-> (o_result.temperature_tenths == 16'sd0 && o_result.pressure_pa == 20'd0), "fault result not zero")

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
